// ----- sv/holonomic_drive_mixer_defines.svh -----
// holonomic_drive_mixer_defines.svh: assertion macros for the drive mixer
// included by the top level; no other dependencies
`ifndef HOLONOMIC_DRIVE_MIXER_DEFINES_SVH
`define HOLONOMIC_DRIVE_MIXER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HDM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdm: same-cycle check failed");
// next-cycle implication
`define HDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdm: next-cycle check failed");
`else
`define HDM_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define HDM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/hdm_pkg.sv -----
`timescale 1ns / 1ps
// hdm_pkg: field widths, scale constants and payload types of the drive mixer
// no dependencies
package hdm_pkg;
   localparam int STICK_W           = 8;
   localparam int SPEED_W           = 16;
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int FULL_SCALE_PCT    = 100;
   localparam int PCT_W             = 7;
   // |-128| still fits unsigned
   localparam int ABS_W             = STICK_W;
   localparam int SUM_W             = ABS_W + 1;
   // |F+S| * max(|F|,|S|) tops out at 2^15
   localparam int PROD_W            = 2 * ABS_W;
   // quotient bits resolved per divider stage
   localparam int DIV_STEPS         = 4;

   typedef logic signed [STICK_W-1:0] stick_type;
   typedef logic signed [SPEED_W-1:0] speed_type;
endpackage

// ----- sv/hdm_if.sv -----
`timescale 1ns / 1ps
// hdm_req_if, hdm_rsp_if: valid/ready channels of the drive mixer
// depends on hdm_pkg
interface hdm_req_if;
   import hdm_pkg::*;
   logic      valid;
   logic      ready;
   stick_type forward;
   stick_type strafe;
   stick_type turn;
   modport source (output valid, forward, strafe, turn, input ready);
   modport sink (input valid, forward, strafe, turn, output ready);
endinterface

interface hdm_rsp_if;
   import hdm_pkg::*;
   logic      valid;
   logic      ready;
   speed_type front_left_speed;
   speed_type back_left_speed;
   speed_type front_right_speed;
   speed_type back_right_speed;
   modport source (output valid, front_left_speed, back_left_speed, front_right_speed,
                   back_right_speed, input ready);
   modport sink (input valid, front_left_speed, back_left_speed, front_right_speed,
                 back_right_speed, output ready);
endinterface

// ----- sv/holonomic_drive_mixer.sv -----
`timescale 1ns / 1ps
// holonomic_drive_mixer: four-wheel speed mixer for an X / mecanum drive
// depends on hdm_pkg, hdm_if.sv and holonomic_drive_mixer_defines.svh
//
//   channel   dir   handshake     word
//   req_chan  in    valid/ready   forward, strafe, turn (s8 percent)
//   rsp_chan  out   valid/ready   four wheel speeds (s16, percent * 2^FRAC_BITS)
//
// one word per cycle in and out while rsp_chan.ready holds; two restoring
// dividers in the pipeline resolve four quotient bits per stage.
// synchronous reset clears only the stage valid bits.
// a stalled output holds; upstream stages keep filling empty slots behind it.
`include "holonomic_drive_mixer_defines.svh"
module holonomic_drive_mixer #(
   parameter int FRAC_BITS = hdm_pkg::FRAC_BITS_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   hdm_req_if.sink   req_chan,
   hdm_rsp_if.source rsp_chan
);
   import hdm_pkg::*;

   localparam int K1    = ABS_W + FRAC_BITS;
   localparam int N1W   = PROD_W + FRAC_BITS;
   localparam int R1W   = SUM_W + 1;
   localparam int PS_W  = SUM_W + 1;
   localparam int WW    = ABS_W + FRAC_BITS + 2;
   localparam int AW    = WW - 1;
   localparam int R2W   = AW + 1;
   localparam int K2    = PCT_W + FRAC_BITS;
   localparam int N2W   = AW + K2;
   localparam int D1S   = (K1 + DIV_STEPS - 1) / DIV_STEPS;
   localparam int D2S   = (K2 + DIV_STEPS - 1) / DIV_STEPS;
   localparam int MIX_I = D1S + 1;
   localparam int ABS_I = D1S + 2;
   localparam int LIM_I = D1S + 3;
   localparam int OUT_I = LIM_I + D2S + 1;
   localparam int NS    = OUT_I + 1;
   localparam logic [AW-1:0] LIM_VAL = AW'(FULL_SCALE_PCT) << FRAC_BITS;

   typedef struct packed {
      logic [R1W-1:0] rem;
      logic [K1-1:0]  qf;
   } l1_type;

   typedef struct packed {
      logic [SUM_W-1:0] den;
      l1_type           lp;
      l1_type           lq;
      logic             sp;
      logic             sq;
      stick_type        turn;
   } d1_type;

   typedef logic signed [WW-1:0] wheel_type;

   typedef struct packed {
      logic [3:0][AW-1:0] aw;
      logic [3:0]         neg;
      logic [AW-1:0]      m01;
      logic [AW-1:0]      m23;
   } ab_type;

   typedef struct packed {
      logic [R2W-1:0] rem;
      logic [K2-1:0]  qf;
   } l2_type;

   typedef struct packed {
      logic [AW-1:0]     den;
      l2_type [3:0]      ln;
      logic [3:0]        neg;
   } d2_type;

   // restoring division: qf carries the remaining dividend bits out at the top
   // and the quotient bits in at the bottom
   function automatic l1_type d1_steps(input l1_type cur, input logic [SUM_W-1:0] den,
                                       input int first);
      l1_type         nxt;
      logic [R1W-1:0] trial;
      nxt = cur;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (first + k < K1) begin
            trial = {nxt.rem[R1W-2:0], nxt.qf[K1-1]};
            if (trial >= R1W'(den)) begin
               nxt.rem = trial - R1W'(den);
               nxt.qf  = {nxt.qf[K1-2:0], 1'b1};
            end else begin
               nxt.rem = trial;
               nxt.qf  = {nxt.qf[K1-2:0], 1'b0};
            end
         end
      end
      return nxt;
   endfunction

   function automatic l2_type d2_steps(input l2_type cur, input logic [AW-1:0] den,
                                       input int first);
      l2_type         nxt;
      logic [R2W-1:0] trial;
      nxt = cur;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (first + k < K2) begin
            trial = {nxt.rem[R2W-2:0], nxt.qf[K2-1]};
            if (trial >= R2W'(den)) begin
               nxt.rem = trial - R2W'(den);
               nxt.qf  = {nxt.qf[K2-2:0], 1'b1};
            end else begin
               nxt.rem = trial;
               nxt.qf  = {nxt.qf[K2-2:0], 1'b0};
            end
         end
      end
      return nxt;
   endfunction

   logic [NS:0]   move;
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] vld_in;

   logic [ABS_W-1:0]      abs_f;
   logic [ABS_W-1:0]      abs_s;
   logic [ABS_W-1:0]      max_fs;
   logic [SUM_W-1:0]      sum_abs;
   logic signed [PS_W-1:0] p_sum;
   logic signed [PS_W-1:0] q_sum;
   logic [SUM_W-1:0]      p_mag;
   logic [SUM_W-1:0]      q_mag;
   logic [PROD_W-1:0]     p_prod;
   logic [PROD_W-1:0]     q_prod;
   logic [N1W-1:0]        p_num;
   logic [N1W-1:0]        q_num;
   d1_type                d1_ff [D1S+1];
   d1_type                d1_in [D1S+1];

   wheel_type             tr_p;
   wheel_type             tr_q;
   wheel_type             turn_u;
   wheel_type             wh_ff [4];
   wheel_type             wh_in [4];

   ab_type                ab_ff;
   ab_type                ab_in;

   logic [AW-1:0]         m_pair;
   logic [N2W-1:0]        n2 [4];
   d2_type                d2_ff [D2S+1];
   d2_type                d2_in [D2S+1];

   logic signed [K2:0]    qs [4];
   speed_type             spd_ff [4];
   speed_type             spd_in [4];

   // stall chain: a stage moves when it is empty or the one after it moves
   always_comb begin
      move[NS] = rsp_chan.ready;
      for (int i = NS - 1; i >= 0; i--) begin
         move[i] = !vld_ff[i] || move[i+1];
      end
      vld_in[0] = move[0] ? req_chan.valid : vld_ff[0];
      for (int i = 1; i < NS; i++) begin
         vld_in[i] = move[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_chan.ready = move[0];
   assign rsp_chan.valid = vld_ff[OUT_I];

   // entry stage and first divider: |F+S| and |F-S|, each * max / (|F|+|S|)
   always_comb begin
      abs_f   = req_chan.forward[STICK_W-1] ? ABS_W'(-req_chan.forward)
                                            : ABS_W'(req_chan.forward);
      abs_s   = req_chan.strafe[STICK_W-1] ? ABS_W'(-req_chan.strafe)
                                           : ABS_W'(req_chan.strafe);
      max_fs  = (abs_f > abs_s) ? abs_f : abs_s;
      sum_abs = SUM_W'(abs_f) + SUM_W'(abs_s);
      p_sum   = PS_W'(req_chan.forward) + PS_W'(req_chan.strafe);
      q_sum   = PS_W'(req_chan.forward) - PS_W'(req_chan.strafe);
      p_mag   = p_sum[PS_W-1] ? SUM_W'(-p_sum) : SUM_W'(p_sum);
      q_mag   = q_sum[PS_W-1] ? SUM_W'(-q_sum) : SUM_W'(q_sum);
      p_prod  = PROD_W'(p_mag) * PROD_W'(max_fs);
      q_prod  = PROD_W'(q_mag) * PROD_W'(max_fs);
      p_num   = N1W'(p_prod) << FRAC_BITS;
      q_num   = N1W'(q_prod) << FRAC_BITS;

      // both sticks centered: sums are zero, any divisor gives zero
      d1_in[0].den     = (sum_abs == '0) ? SUM_W'(1) : sum_abs;
      d1_in[0].lp.rem  = R1W'(p_num >> K1);
      d1_in[0].lp.qf   = K1'(p_num);
      d1_in[0].lq.rem  = R1W'(q_num >> K1);
      d1_in[0].lq.qf   = K1'(q_num);
      d1_in[0].sp      = p_sum[PS_W-1];
      d1_in[0].sq      = q_sum[PS_W-1];
      d1_in[0].turn    = req_chan.turn;

      for (int g = 1; g <= D1S; g++) begin
         d1_in[g]    = d1_ff[g-1];
         d1_in[g].lp = d1_steps(d1_ff[g-1].lp, d1_ff[g-1].den, (g - 1) * DIV_STEPS);
         d1_in[g].lq = d1_steps(d1_ff[g-1].lq, d1_ff[g-1].den, (g - 1) * DIV_STEPS);
      end
   end

   // rotation mix
   always_comb begin
      tr_p     = WW'(d1_ff[D1S].lp.qf);
      tr_q     = WW'(d1_ff[D1S].lq.qf);
      if (d1_ff[D1S].sp) begin
         tr_p = -tr_p;
      end
      if (d1_ff[D1S].sq) begin
         tr_q = -tr_q;
      end
      turn_u   = WW'(d1_ff[D1S].turn) <<< FRAC_BITS;
      wh_in[0] = tr_p + turn_u;
      wh_in[1] = tr_q + turn_u;
      wh_in[2] = tr_q - turn_u;
      wh_in[3] = tr_p - turn_u;
   end

   // magnitudes and pairwise maxima
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ab_in.neg[i] = wh_ff[i][WW-1];
         ab_in.aw[i]  = wh_ff[i][WW-1] ? AW'(-wh_ff[i]) : AW'(wh_ff[i]);
      end
      ab_in.m01 = (ab_in.aw[0] > ab_in.aw[1]) ? ab_in.aw[0] : ab_in.aw[1];
      ab_in.m23 = (ab_in.aw[2] > ab_in.aw[3]) ? ab_in.aw[2] : ab_in.aw[3];
   end

   // limit divisor and second divider: |w| * 100U / m
   always_comb begin
      m_pair       = (ab_ff.m01 > ab_ff.m23) ? ab_ff.m01 : ab_ff.m23;
      d2_in[0].den = (m_pair > LIM_VAL) ? m_pair : LIM_VAL;
      d2_in[0].neg = ab_ff.neg;
      for (int i = 0; i < 4; i++) begin
         n2[i]             = (N2W'(ab_ff.aw[i]) * N2W'(FULL_SCALE_PCT)) << FRAC_BITS;
         d2_in[0].ln[i].rem = R2W'(n2[i] >> K2);
         d2_in[0].ln[i].qf  = K2'(n2[i]);
      end
      for (int g = 1; g <= D2S; g++) begin
         d2_in[g] = d2_ff[g-1];
         for (int i = 0; i < 4; i++) begin
            d2_in[g].ln[i] = d2_steps(d2_ff[g-1].ln[i], d2_ff[g-1].den,
                                      (g - 1) * DIV_STEPS);
         end
      end
   end

   // restore signs, keep the low bits of each speed
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         qs[i] = (K2 + 1)'(d2_ff[D2S].ln[i].qf);
         if (d2_ff[D2S].neg[i]) begin
            qs[i] = -qs[i];
         end
         spd_in[i] = SPEED_W'(qs[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= D1S; i++) begin
         if (move[i]) begin
            d1_ff[i] <= d1_in[i];
         end
      end
      if (move[MIX_I]) begin
         wh_ff <= wh_in;
      end
      if (move[ABS_I]) begin
         ab_ff <= ab_in;
      end
      for (int i = 0; i <= D2S; i++) begin
         if (move[LIM_I+i]) begin
            d2_ff[i] <= d2_in[i];
         end
      end
      if (move[OUT_I]) begin
         spd_ff <= spd_in;
      end
   end

   assign rsp_chan.front_left_speed  = spd_ff[0];
   assign rsp_chan.back_left_speed   = spd_ff[1];
   assign rsp_chan.front_right_speed = spd_ff[2];
   assign rsp_chan.back_right_speed  = spd_ff[3];

   `HDM_ASSERT_IMPLY(a_div1_rem, clock, reset, vld_ff[D1S], d1_ff[D1S].lp.rem < R1W'(d1_ff[D1S].den))
   `HDM_ASSERT_IMPLY(a_lim_floor, clock, reset, vld_ff[LIM_I], d2_ff[0].den >= LIM_VAL)
   `HDM_ASSERT_IMPLY(a_quo_bound, clock, reset, vld_ff[LIM_I+D2S], d2_ff[D2S].ln[0].qf <= K2'(LIM_VAL))
   `HDM_ASSERT_NEXT(a_mix_fill, clock, reset, vld_ff[D1S] && move[MIX_I], vld_ff[MIX_I])
endmodule

// ----- tb/holonomic_drive_mixer_tb.sv -----
`timescale 1ns / 1ps
// holonomic_drive_mixer_tb: checks every wheel-speed word of the drive mixer against
// an independent fixed-point mixing model, or against the speeds of a directed row
// marked 1, under three sender/receiver idle mixes; depends on hdm_pkg, hdm_if.sv and holonomic_drive_mixer.sv
module holonomic_drive_mixer_tb;
   import hdm_pkg::*;

   localparam int FB              = FRAC_BITS_DEFAULT;
   localparam int LATENCY         = 4 + (8 + FB + 3) / 4 + (7 + FB + 3) / 4 + 1;
   localparam int TAIL_CYCLES     = 2 * LATENCY;
   localparam int ITEMS_PER_PHASE = 626;
   localparam int NUM_PHASES      = 3;
   localparam int HOLD_CYCLES     = 300;
   localparam int WATCHDOG_LIMIT  = 5000;
   localparam int NUM_DIRECTED    = 24;

   typedef struct packed {
      speed_type fl_spd;
      speed_type bl_spd;
      speed_type fr_spd;
      speed_type br_spd;
   } wheel_speeds_type;

   typedef struct packed {
      stick_type        forward;
      stick_type        strafe;
      stick_type        turn;
      bit               typed;
      wheel_speeds_type speeds;
   } mix_row_type;

   // rows marked 1 carry speeds that follow directly from the mixing rules
   localparam mix_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{   0,    0,    0, 1, '{     0,      0,      0,      0}},
      '{ 100,    0,    0, 1, '{ 25600,  25600,  25600,  25600}},
      '{-100,    0,    0, 1, '{-25600, -25600, -25600, -25600}},
      '{   0,  100,    0, 1, '{ 25600, -25600, -25600,  25600}},
      '{   0, -100,    0, 1, '{-25600,  25600,  25600, -25600}},
      '{   0,    0,  100, 1, '{ 25600,  25600, -25600, -25600}},
      '{   0,    0, -128, 1, '{-25600, -25600,  25600,  25600}},
      '{  50,   50,    0, 1, '{ 12800,      0,      0,  12800}},
      '{ 100,    0,  100, 1, '{ 25600,  25600,      0,      0}},
      '{-128,    0,    0, 1, '{-25600, -25600, -25600, -25600}},
      '{ 127,    0,    0, 1, '{ 25600,  25600,  25600,  25600}},
      '{   0, -128,    0, 0, '{0, 0, 0, 0}},
      '{   0,  127,    0, 0, '{0, 0, 0, 0}},
      '{  37,  -81,   12, 0, '{0, 0, 0, 0}},
      '{-128, -128, -128, 0, '{0, 0, 0, 0}},
      '{ 127,  127,  127, 0, '{0, 0, 0, 0}},
      '{-128,  127,   -1, 0, '{0, 0, 0, 0}},
      '{   1,   -1,    1, 0, '{0, 0, 0, 0}},
      '{  -1,    0,    0, 0, '{0, 0, 0, 0}},
      '{  99,   -3, -100, 0, '{0, 0, 0, 0}},
      '{-100,  100, -100, 0, '{0, 0, 0, 0}},
      '{  60,   40,   30, 0, '{0, 0, 0, 0}},
      '{ 100,  100,  100, 0, '{0, 0, 0, 0}},
      '{ -55,  -20,  127, 0, '{0, 0, 0, 0}}
   };

   logic clock;
   logic reset;

   hdm_req_if req_chan ();
   hdm_rsp_if rsp_chan ();

   holonomic_drive_mixer #(.FRAC_BITS(FB)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mix_row_type      offered_rows [$];
   wheel_speeds_type speeds_due [$];
   int               mismatches      = 0;
   int               words_in        = 0;
   int               results_checked = 0;
   int               quiet_cycles    = 0;
   int               sender_idle_pct = 0;
   int               rsp_idle_pct    = 0;
   bit               hold_start      = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // fixed-point mix: scaled translation, turn added left / subtracted right,
   // then all four pulled back proportionally if any wheel passes full scale
   function automatic wheel_speeds_type mix_wheels(stick_type fwd, stick_type str,
                                                   stick_type trn);
      longint unit, mag_fwd, mag_str, sum_abs, max_abs, full, peak, v;
      longint w [4];
      longint speed [4];
      wheel_speeds_type r;
      unit    = longint'(1) << FB;
      mag_fwd = (fwd < 0) ? -longint'(fwd) : longint'(fwd);
      mag_str = (str < 0) ? -longint'(str) : longint'(str);
      sum_abs = mag_fwd + mag_str;
      max_abs = (mag_fwd > mag_str) ? mag_fwd : mag_str;
      w[0] = longint'(fwd) + longint'(str);
      w[1] = longint'(fwd) - longint'(str);
      w[2] = w[1];
      w[3] = w[0];
      for (int i = 0; i < 4; i++) begin
         if (sum_abs != 0) w[i] = (w[i] * max_abs * unit) / sum_abs;
         else w[i] = w[i] * unit;
      end
      w[0] += longint'(trn) * unit;
      w[1] += longint'(trn) * unit;
      w[2] -= longint'(trn) * unit;
      w[3] -= longint'(trn) * unit;
      full = longint'(FULL_SCALE_PCT) * unit;
      peak = full;
      for (int i = 0; i < 4; i++) begin
         v = (w[i] < 0) ? -w[i] : w[i];
         if (v > peak) peak = v;
      end
      for (int i = 0; i < 4; i++) speed[i] = (w[i] * full) / peak;
      r.fl_spd = speed[0][SPEED_W-1:0];
      r.bl_spd = speed[1][SPEED_W-1:0];
      r.fr_spd = speed[2][SPEED_W-1:0];
      r.br_spd = speed[3][SPEED_W-1:0];
      return r;
   endfunction

   // mostly nominal sticks, with centered, extreme and out-of-range values mixed in
   function automatic stick_type pick_stick();
      int sel;
      sel = $urandom_range(99);
      if (sel < 65) return stick_type'(int'($urandom_range(200)) - 100);
      if (sel < 75) return '0;
      if (sel < 83) return $urandom_range(1) ? stick_type'(100) : stick_type'(-100);
      if (sel < 93) return stick_type'($urandom_range(255));
      return $urandom_range(1) ? stick_type'(1) : stick_type'(-1);
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch @%0t result %0d: %s", $time, results_checked, what);
      mismatches++;
   endtask

   task automatic check_speed(string field, speed_type got, speed_type want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", field, got, want));
   endtask

   task automatic send_word(mix_row_type row);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      offered_rows.push_back(row);
      req_chan.valid   <= 1'b1;
      req_chan.forward <= row.forward;
      req_chan.strafe  <= row.strafe;
      req_chan.turn    <= row.turn;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic wait_for_speeds();
      req_chan.valid <= 1'b0;
      while (speeds_due.size() != 0 || offered_rows.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // receiver: random back-pressure, or a long hold-off when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 0;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // check results before queuing this edge's word: a word taken at this edge cannot leave at it
   always @(posedge clock) begin
      wheel_speeds_type want;
      mix_row_type      offered;
      logic             moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_chan.valid && rsp_chan.ready) begin
            moved = 1'b1;
            if (speeds_due.size() == 0) begin
               report_mismatch("result word with nothing outstanding");
            end else begin
               want = speeds_due.pop_front();
               check_speed("front_left_speed", rsp_chan.front_left_speed, want.fl_spd);
               check_speed("back_left_speed", rsp_chan.back_left_speed, want.bl_spd);
               check_speed("front_right_speed", rsp_chan.front_right_speed, want.fr_spd);
               check_speed("back_right_speed", rsp_chan.back_right_speed, want.br_spd);
               results_checked++;
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            moved = 1'b1;
            words_in++;
            offered = '0;
            if (offered_rows.size() != 0) offered = offered_rows.pop_front();
            if (offered.typed) speeds_due.push_back(offered.speeds);
            else speeds_due.push_back(mix_wheels(req_chan.forward, req_chan.strafe,
                                                 req_chan.turn));
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   initial begin
      mix_row_type row;
      reset            <= 1'b1;
      req_chan.valid   <= 1'b0;
      req_chan.forward <= '0;
      req_chan.strafe  <= '0;
      req_chan.turn    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         unique case (phase)
            0: begin
               sender_idle_pct = 37;
               rsp_idle_pct    = 73;
            end
            1: begin
               sender_idle_pct = 73;
               rsp_idle_pct    = 37;
            end
            default: begin
               sender_idle_pct = 0;
               rsp_idle_pct    = 0;
               // output stalls while input keeps coming, so the pipe backs up
               hold_start      = 1;
            end
         endcase
         if (phase == 0)
            for (int i = 0; i < NUM_DIRECTED; i++) send_word(DIRECTED_ROWS[i]);
         repeat (ITEMS_PER_PHASE) begin
            row         = '0;
            row.forward = pick_stick();
            row.strafe  = pick_stick();
            row.turn    = pick_stick();
            send_word(row);
         end
         wait_for_speeds();
      end
      if (speeds_due.size() != 0)
         report_mismatch($sformatf("%0d expected words never arrived", speeds_due.size()));
      $display("covered %0d words (%0d directed) over three idle mixes and a %0d-cycle hold",
               words_in, NUM_DIRECTED, HOLD_CYCLES);
      $display("%0d result words checked, %0d mismatches", results_checked, mismatches);
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/hdm_pkg.sv
sv/hdm_if.sv
sv/holonomic_drive_mixer.sv
tb/holonomic_drive_mixer_tb.sv
